// ===== hdl/lrukv_pkg.sv =====
package lrukv_pkg;

  // operation codes carried on in_tuser
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // capacity register width and reset value
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // controller to datapath commands
  typedef struct packed {
    logic latch;    // capture the input beat
    logic look;     // register the parallel key compare
    logic update;   // apply the table update
    logic respond;  // load the output register
  } lrukv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_room; // output register can take a result
  } lrukv_sts_t;

endpackage

// ===== hdl/lrukv_ctrl.sv =====
module lrukv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output lrukv_pkg::lrukv_cmd_t cmd,
  input  lrukv_pkg::lrukv_sts_t sts
);
  import lrukv_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_room) begin
          cmd.respond = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lrukv_dp.sv =====
module lrukv_dp #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lrukv_pkg::lrukv_cmd_t       cmd,
  output lrukv_pkg::lrukv_sts_t       sts,
  input  logic                        in_op,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic                        cfg_wr_en,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [VALUE_BITS-1:0]       out_value
);
  import lrukv_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // item under work
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // table
  logic [KEY_BITS-1:0]   tag_r   [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [ENTRIES-1:0]    valid_nxt;
  logic [IDX_W-1:0]      rank_r  [ENTRIES];
  logic [IDX_W-1:0]      rank_nxt[ENTRIES];
  logic [CNT_W-1:0]      occ_r;
  logic [CNT_W-1:0]      occ_nxt;
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [VALUE_BITS-1:0] rd_r;

  // capacity
  logic [CAP_W-1:0]      cfg_cap_r;
  logic                  cap_held_r;
  logic                  cap_held_nxt;
  logic [CNT_W-1:0]      held_cap_r;
  logic [CNT_W-1:0]      held_cap_nxt;
  logic [CNT_W-1:0]      cap_clamp;
  logic [CNT_W-1:0]      cap_use;

  // lookup results
  logic                  hit_c, lru_any_c;
  logic [IDX_W-1:0]      hit_idx_c, free_idx_c, lru_idx_c;
  logic                  hit_r, lru_any_r;
  logic [IDX_W-1:0]      hit_idx_r, free_idx_r, lru_idx_r;

  // update controls
  logic                  wr_en;
  logic                  tag_wr;
  logic [IDX_W-1:0]      slot;
  logic                  do_promote;
  logic [CNT_W-1:0]      prom_old;
  logic                  get_hit_r;

  // output register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_value_r;

  assign sts.out_room = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_value    = out_value_r;

  always_comb begin
    if (cfg_cap_r == '0) begin
      cap_clamp = CNT_W'(1);
    end else if (int'(cfg_cap_r) > int'(ENTRIES)) begin
      cap_clamp = CNT_W'(ENTRIES);
    end else begin
      cap_clamp = CNT_W'(cfg_cap_r);
    end
  end

  // parallel compare and lowest-index searches
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    lru_any_c  = 1'b0;
    lru_idx_c  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == key_r) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx_c = IDX_W'(i);
      end
      if (valid_r[i] && (CNT_W'(rank_r[i]) + CNT_W'(1)) == occ_r) begin
        lru_any_c = 1'b1;
        lru_idx_c = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    rank_nxt     = rank_r;
    occ_nxt      = occ_r;
    cap_held_nxt = cap_held_r;
    held_cap_nxt = held_cap_r;
    cap_use      = cap_held_r ? held_cap_r : cap_clamp;
    wr_en        = 1'b0;
    tag_wr       = 1'b0;
    slot         = hit_idx_r;
    do_promote   = 1'b0;
    prom_old     = occ_r;
    if (cmd.update) begin
      if (hit_r) begin
        do_promote = 1'b1;
        prom_old   = CNT_W'(rank_r[hit_idx_r]);
        wr_en      = (op_r == OP_PUT);
      end else if (op_r == OP_PUT) begin
        cap_held_nxt = 1'b1;
        held_cap_nxt = cap_use;
        if (occ_r < cap_use) begin
          slot = free_idx_r;
        end else begin
          slot = lru_any_r ? lru_idx_r : '0;
        end
        wr_en      = 1'b1;
        tag_wr     = 1'b1;
        do_promote = 1'b1;
        if (!valid_r[slot]) begin
          valid_nxt[slot] = 1'b1;
          occ_nxt         = occ_r + CNT_W'(1);
          prom_old        = occ_r + CNT_W'(1);
        end
      end
      if (do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && IDX_W'(i) != slot && CNT_W'(rank_r[i]) < prom_old) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        rank_nxt[slot] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occ_r      <= '0;
      cap_held_r <= 1'b0;
      held_cap_r <= '0;
      cfg_cap_r  <= CAP_RST;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r    <= valid_nxt;
      occ_r      <= occ_nxt;
      cap_held_r <= cap_held_nxt;
      held_cap_r <= held_cap_nxt;
      rank_r     <= rank_nxt;
      if (cfg_wr_en) begin
        cfg_cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.look) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      free_idx_r <= free_idx_c;
      lru_any_r  <= lru_any_c;
      lru_idx_r  <= lru_idx_c;
    end
    if (cmd.update) begin
      get_hit_r <= hit_r && (op_r == OP_GET);
    end
    if (tag_wr) begin
      tag_r[slot] <= key_r;
    end
  end

  // value store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[slot] <= val_r;
    end
    rd_r <= val_mem[hit_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_hit_r   <= hit_r;
      out_value_r <= get_hit_r ? rd_r : '0;
    end
  end

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupied count out of step with valid marks");

  a_cap_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    cap_held_r |=> (cap_held_r && $stable(held_cap_r)))
    else $error("held capacity changed after first insertion");

  a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cap_held_r |-> (occ_r <= held_cap_r))
    else $error("cache holds more entries than its capacity");
`endif

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// channel | dir | tdata (low bit up)           | tuser
// in_     | in  | key, value, zero pad to byte | operation (0 get, 1 put)
// out_    | out | read_value, zero pad to byte | hit
// cfg_    | in  | capacity_in_use on cfg_wr_data, written when cfg_wr_en is high
//
// each item passes in turn through accept, parallel key compare, table update, result load
// the key compare across every entry and the value store read port call for those steps
// a finished result sits in the output register, so the next beat is taken meanwhile
// a result load waits only while the output register is full and out_tready is low
// synchronous active-low reset clears valid marks, recency ranks and the count
// capacity is sampled at the first insertion after reset and held until reset
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // input beats
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     in_tdata,  // key, value
  input  logic                                         in_tuser,  // operation
  // result beats
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]              out_tdata, // read_value
  output logic                                         out_tuser, // hit
  // capacity register
  input  logic                                         cfg_wr_en,
  input  logic [lrukv_pkg::CAP_W-1:0]                  cfg_wr_data
);
  import lrukv_pkg::*;

  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8;

  lrukv_cmd_t            cmd;
  lrukv_sts_t            sts;
  logic [VALUE_BITS-1:0] rd_value;

  // sequencing of each item
  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // tag compare, recency ranks, value store and output register
  lrukv_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_tuser),
    .in_key      (in_tdata[KEY_BITS-1:0]),
    .in_value    (in_tdata[KEY_BITS +: VALUE_BITS]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_hit     (out_tuser),
    .out_value   (rd_value)
  );

  // pad to whole bytes
  assign out_tdata = OUT_W'(rd_value);

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lrukv_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned KEY_W         = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned POOL_SIZE     = 24;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES  = 200000;

  // one predicted response: hit flag and the value a get hit returns
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } cache_answer_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [KEY_W+VAL_W-1:0] in_tdata;   // key, value
  logic                   in_tuser;   // operation
  logic                   out_tvalid;
  logic                   out_tready;
  logic [VAL_W-1:0]       out_tdata;  // read_value
  logic                   out_tuser;  // hit
  logic                   cfg_wr_en;
  logic [CAP_W-1:0]       cfg_wr_data;

  lru_key_value_cache #(
    .ENTRIES    (SLOTS),
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VAL_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow copy of the cache contents and its recency order
  logic [KEY_W-1:0] stored_key [SLOTS];
  logic [VAL_W-1:0] stored_val [SLOTS];
  bit               live       [SLOTS];
  int unsigned      age_rank   [SLOTS];   // 0 is the most recently used
  int unsigned      fill_count;
  logic [CAP_W-1:0] cap_reg;              // last value written to the register
  int unsigned      cap_latched;          // capacity frozen at the first insertion
  bit               cap_is_latched;

  cache_answer_t    expected_answers [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      hold_len       = 0;   // long receiver hold-off, counted down below
  bit               idle_on        = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a run that never drains ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // move an entry to the front; everything younger than its old rank ages by one
  function automatic void touch_entry(int idx, int unsigned old_rank);
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && i != idx && age_rank[i] < old_rank) age_rank[i]++;
    end
    age_rank[idx] = 0;
  endfunction

  // apply one request to the shadow cache and return what the block should answer
  function automatic cache_answer_t cache_lookup_update(logic op, logic [KEY_W-1:0] key,
                                                        logic [VAL_W-1:0] val);
    cache_answer_t ans;
    int            found;
    int            slot;
    ans   = '0;
    found = -1;
    slot  = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && live[i] && stored_key[i] == key) found = i;
    end
    if (found >= 0) begin
      // hit: get returns the value, put overwrites it and answers zero
      ans.hit = 1'b1;
      if (op == OP_GET) ans.read_value = stored_val[found];
      else stored_val[found] = val;
      touch_entry(found, age_rank[found]);
    end else if (op == OP_PUT) begin
      // capacity is frozen at the first insertion; zero means one, large means all
      if (!cap_is_latched) begin
        if (cap_reg == 0) cap_latched = 1;
        else if (cap_reg > SLOTS) cap_latched = SLOTS;
        else cap_latched = 32'(cap_reg);
        cap_is_latched = 1'b1;
      end
      if (fill_count < cap_latched) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !live[i]) slot = i;
        end
      end
      // full: reuse the slot of the least recently used entry
      if (slot < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && live[i] && age_rank[i] + 1 == fill_count) slot = i;
        end
        if (slot < 0) slot = 0;
      end
      stored_key[slot] = key;
      stored_val[slot] = val;
      if (!live[slot]) begin
        live[slot] = 1'b1;
        fill_count++;
      end
      touch_entry(slot, fill_count);
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // result side: compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    cache_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, '0);
      end else begin
        want = expected_answers.pop_front();
        if (out_tuser !== want.hit)
          report_mismatch("hit", VAL_W'(out_tuser), VAL_W'(want.hit));
        if (out_tdata !== want.read_value)
          report_mismatch("read_value", out_tdata, want.read_value);
      end
    end
  end

  // receiver: long hold-off takes priority, then random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_tready <= 1'b0;
        hold_len--;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one request beat, optionally after a gap, and predict it once taken;
  // tvalid stays high afterwards so back-to-back beats need no extra edge
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, key};
    do @(posedge clk); while (!in_tready);
    expected_answers.push_back(cache_lookup_update(op, key, val));
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cap_reg = cap;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly keys from a pool a little larger than the capacity, so hits and
  // evictions both happen; the rest anywhere in the key space
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, cap_latched + 3)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(0, 1) == 0) ? OP_GET : OP_PUT;
  endfunction

  // lookups on an empty cache all miss
  task automatic test_empty_lookups();
    send_request(OP_GET, '0, '0);
    send_request(OP_GET, '1, '1);
  endtask

  // insert, hit, update through a put hit, and a plain miss
  task automatic test_basic_hits();
    send_request(OP_PUT, '0, '0);
    send_request(OP_PUT, '1, '1);
    send_request(OP_GET, '1, '0);
    send_request(OP_PUT, '1, 32'h5a5a_5a5a);
    send_request(OP_GET, 16'h1234, '1);
  endtask

  // overfill the cache so the oldest entries are evicted, then look one up
  task automatic test_eviction();
    for (int i = 0; i <= SLOTS; i++) send_request(OP_PUT, KEY_W'(16'h0100 + i), $urandom);
    send_request(OP_GET, '0, '0);
  endtask

  // mixed traffic, idling switched off for every third stretch
  task automatic test_random_traffic(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) idle_on = ((i / 60) % 3 != 2);
      send_request(pick_op(), pick_key(), $urandom);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_len = 250;
    repeat (30) send_request(pick_op(), pick_key(), $urandom);
  endtask

  // sender pauses until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    idle_on = 1'b1;
    repeat (20) send_request(pick_op(), pick_key(), $urandom);
    settle();
    repeat (20) send_request(pick_op(), pick_key(), $urandom);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate(input int unsigned n);
    idle_on = 1'b0;
    repeat (n) send_request(pick_op(), pick_key(), $urandom);
  endtask

  initial begin
    int unsigned cap_pick;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_GET;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      stored_key[i] = '0;
      stored_val[i] = '0;
      live[i]       = 1'b0;
      age_rank[i]   = 0;
    end
    fill_count     = 0;
    cap_reg        = CAP_RST;
    cap_latched    = 0;
    cap_is_latched = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register extremes before any insertion; the last write before the first
    // put is the capacity that holds for the whole run
    write_capacity('0);
    test_empty_lookups();
    settle();
    write_capacity('1);
    cap_pick = $urandom_range(0, 17);
    write_capacity((cap_pick == 17) ? CAP_W'(31) : CAP_W'(cap_pick));
    test_basic_hits();
    test_eviction();
    settle();

    // later writes must leave the frozen capacity alone
    write_capacity(CAP_W'(1));
    test_random_traffic(300);
    settle();
    write_capacity(CAP_W'(SLOTS));
    test_backpressure();
    test_drain_pause();
    test_random_traffic(300);
    settle();
    write_capacity('1);
    test_full_rate(120);
    settle();

    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
